// ===== src/ppts_pkg.sv =====
// Shared types and constants for the perspective projection block.
// Depends on nothing; every other file refers to it by scoped names.
package ppts_pkg;

  localparam int CfgIdxW = 4;
  localparam int DimW = 14;
  localparam int NumW = 32 + DimW;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] HID_POS_LIM = 32'sd21474;
  localparam logic signed [31:0] HID_NEG_LIM = -32'sd21474;
  localparam logic signed [17:0] HID_SCALE = 18'sd100000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW0_XY = 4'd0,
    REG_ROW0_ZW = 4'd1,
    REG_ROW1_XY = 4'd2,
    REG_ROW1_ZW = 4'd3,
    REG_ROW3_XY = 4'd4,
    REG_ROW3_ZW = 4'd5,
    REG_WIDTH   = 4'd6,
    REG_HEIGHT  = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic               vis;
    logic               neg_x;
    logic               neg_y;
    logic signed [31:0] hid_x;
    logic signed [31:0] hid_y;
  } side_t;

endpackage

// ===== src/ppts_dot.sv =====
// Three-stage pipelined dot product of one matrix row with (x, y, z, 1).
// Depends on ppts_pkg for the saturation limits.
module ppts_dot #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic signed [31:0] z_i,
  input  logic        [63:0] row_xy_i,
  input  logic        [63:0] row_zw_i,
  output logic               valid_o,
  output logic signed [31:0] clip_o
);

  logic [2:0] vld_q;
  logic signed [63:0] p0_q, p1_q, p2_q;
  logic signed [65:0] sum_d, sum_q, shf;
  logic signed [66:0] tot;
  logic signed [31:0] clip_d, clip_q;
  logic               ovf;

  always_comb begin
    sum_d = {{2{p0_q[63]}}, p0_q} + {{2{p1_q[63]}}, p1_q} + {{2{p2_q[63]}}, p2_q};
    shf = sum_q >>> FRAC_BITS;
    tot = {shf[65], shf} + {{35{row_zw_i[63]}}, row_zw_i[63:32]};
    ovf = !((&tot[66:31]) || !(|tot[66:31]));
    if (ovf) begin
      clip_d = tot[66] ? ppts_pkg::S32_MIN : ppts_pkg::S32_MAX;
    end else begin
      clip_d = tot[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q   <= $signed(row_xy_i[31:0]) * x_i;
    p1_q   <= $signed(row_xy_i[63:32]) * y_i;
    p2_q   <= $signed(row_zw_i[31:0]) * z_i;
    sum_q  <= sum_d;
    clip_q <= clip_d;
  end

  assign valid_o = vld_q[2];
  assign clip_o  = clip_q;

endmodule

// ===== src/ppts_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two dividends
// sharing one divisor. Depends on ppts_pkg for the sideband type.
module ppts_div #(
  parameter int NW = 62,
  parameter int DW = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NW-1:0]    dvd_x_i,
  input  logic [NW-1:0]    dvd_y_i,
  input  logic [DW-1:0]    den_i,
  input  ppts_pkg::side_t  side_i,
  output logic             valid_o,
  output logic [NW-1:0]    quo_x_o,
  output logic [NW-1:0]    quo_y_o,
  output ppts_pkg::side_t  side_o
);

  logic            vld  [NW+1];
  logic [NW-1:0]   dqx  [NW+1];
  logic [NW-1:0]   dqy  [NW+1];
  logic [DW-1:0]   remx [NW+1];
  logic [DW-1:0]   remy [NW+1];
  logic [DW-1:0]   den  [NW+1];
  ppts_pkg::side_t side [NW+1];

  assign vld[0]  = valid_i;
  assign dqx[0]  = dvd_x_i;
  assign dqy[0]  = dvd_y_i;
  assign remx[0] = '0;
  assign remy[0] = '0;
  assign den[0]  = den_i;
  assign side[0] = side_i;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] trx, try_v;
    logic        gex, gey;

    always_comb begin
      trx   = {remx[s], dqx[s][NW-1]};
      try_v = {remy[s], dqy[s][NW-1]};
      gex   = trx >= {1'b0, den[s]};
      gey   = try_v >= {1'b0, den[s]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      remx[s+1] <= gex ? DW'(trx - {1'b0, den[s]}) : trx[DW-1:0];
      remy[s+1] <= gey ? DW'(try_v - {1'b0, den[s]}) : try_v[DW-1:0];
      dqx[s+1]  <= {dqx[s][NW-2:0], gex};
      dqy[s+1]  <= {dqy[s][NW-2:0], gey};
      den[s+1]  <= den[s];
      side[s+1] <= side[s];
    end
  end

  assign valid_o = vld[NW];
  assign quo_x_o = dqx[NW];
  assign quo_y_o = dqy[NW];
  assign side_o  = side[NW];

endmodule

// ===== src/perspective_project_to_screen.sv =====
// Top level of the perspective projection block: configuration registers,
// clip dot products, near-plane test, pixel division and saturation.
// Depends on ppts_pkg, ppts_dot and ppts_div.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+----------------------------------
//  input     | start_i, busy_o              | world_x_i, world_y_i, world_z_i
//  result    | done_o (one-cycle strobe)    | screen_x_o, screen_y_o, visible_o
//  config    | cfg_valid_i, cfg_ready_o     | cfg_index_i, cfg_data_i
//
// An item may be started in every cycle; busy_o is always low.
// Each result passes the clip dot products, the divider input register, the divider,
// which produces one quotient bit per pipeline stage, and the output register.
// Reset clears the valid bits and loads the register defaults.
// The receiver cannot stall, so nothing is ever held back.
module perspective_project_to_screen #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [31:0]               world_x_i,
  input  logic signed [31:0]               world_y_i,
  input  logic signed [31:0]               world_z_i,
  output logic                             done_o,
  output logic signed [31:0]               screen_x_o,
  output logic signed [31:0]               screen_y_o,
  output logic                             visible_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ppts_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [63:0]                      cfg_data_i
);

  localparam int NW  = ppts_pkg::NumW + FRAC_BITS;
  localparam int SW  = NW + 2;
  localparam int LAT = NW + 5;
  localparam logic signed [31:0] THR = 32'(((1 << FRAC_BITS) + 999) / 1000);

  logic [63:0] row0_xy_q, row0_zw_q, row1_xy_q, row1_zw_q, row3_xy_q, row3_zw_q;
  logic [ppts_pkg::DimW-1:0] width_q, height_q;

  logic accept;
  logic vld_x, vld_y, vld_w;
  logic signed [31:0] cx, cy, cw;

  logic                       s4_vld_q;
  logic [ppts_pkg::NumW-1:0]  numx_q, numy_q;
  logic [32:0]                den_q;
  ppts_pkg::side_t            side_d, side_q;
  logic [31:0]                magx, magy;

  logic            dv_vld;
  logic [NW-1:0]   qx, qy;
  ppts_pkg::side_t dv_side;

  logic signed [SW-1:0] hw, hh, tx, ty, sx, sy;
  logic signed [31:0]   sx_sat, sy_sat;
  logic                 done_q, vis_q;
  logic signed [31:0]   scr_x_q, scr_y_q;

  assign accept      = start_i && !busy_o;
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_xy_q <= '0;
      row0_zw_q <= '0;
      row1_xy_q <= '0;
      row1_zw_q <= '0;
      row3_xy_q <= '0;
      row3_zw_q <= '0;
      width_q   <= 14'd1920;
      height_q  <= 14'd1080;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ppts_pkg::cfg_reg_e'(cfg_index_i))
        ppts_pkg::REG_ROW0_XY: row0_xy_q <= cfg_data_i;
        ppts_pkg::REG_ROW0_ZW: row0_zw_q <= cfg_data_i;
        ppts_pkg::REG_ROW1_XY: row1_xy_q <= cfg_data_i;
        ppts_pkg::REG_ROW1_ZW: row1_zw_q <= cfg_data_i;
        ppts_pkg::REG_ROW3_XY: row3_xy_q <= cfg_data_i;
        ppts_pkg::REG_ROW3_ZW: row3_zw_q <= cfg_data_i;
        ppts_pkg::REG_WIDTH:   width_q   <= cfg_data_i[ppts_pkg::DimW-1:0];
        ppts_pkg::REG_HEIGHT:  height_q  <= cfg_data_i[ppts_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  ppts_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_x (
    .clk_i, .rst_ni, .valid_i(accept),
    .x_i(world_x_i), .y_i(world_y_i), .z_i(world_z_i),
    .row_xy_i(row0_xy_q), .row_zw_i(row0_zw_q),
    .valid_o(vld_x), .clip_o(cx)
  );

  ppts_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_y (
    .clk_i, .rst_ni, .valid_i(accept),
    .x_i(world_x_i), .y_i(world_y_i), .z_i(world_z_i),
    .row_xy_i(row1_xy_q), .row_zw_i(row1_zw_q),
    .valid_o(vld_y), .clip_o(cy)
  );

  ppts_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_w (
    .clk_i, .rst_ni, .valid_i(accept),
    .x_i(world_x_i), .y_i(world_y_i), .z_i(world_z_i),
    .row_xy_i(row3_xy_q), .row_zw_i(row3_zw_q),
    .valid_o(vld_w), .clip_o(cw)
  );

  always_comb begin
    magx = cx[31] ? 32'(-cx) : cx;
    magy = cy[31] ? 32'(-cy) : cy;
    side_d.vis   = !(cw < THR);
    side_d.neg_x = cx[31];
    side_d.neg_y = cy[31];
    if (cx > ppts_pkg::HID_POS_LIM) begin
      side_d.hid_x = ppts_pkg::S32_MAX;
    end else if (cx < ppts_pkg::HID_NEG_LIM) begin
      side_d.hid_x = ppts_pkg::S32_MIN;
    end else begin
      side_d.hid_x = 32'(cx * ppts_pkg::HID_SCALE);
    end
    if (cy > ppts_pkg::HID_POS_LIM) begin
      side_d.hid_y = ppts_pkg::S32_MAX;
    end else if (cy < ppts_pkg::HID_NEG_LIM) begin
      side_d.hid_y = ppts_pkg::S32_MIN;
    end else begin
      side_d.hid_y = 32'(cy * ppts_pkg::HID_SCALE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= vld_x;
    end
  end

  always_ff @(posedge clk_i) begin
    numx_q <= ppts_pkg::NumW'(magx) * ppts_pkg::NumW'(width_q);
    numy_q <= ppts_pkg::NumW'(magy) * ppts_pkg::NumW'(height_q);
    den_q  <= {cw, 1'b0};
    side_q <= side_d;
  end

  ppts_div #(.NW(NW), .DW(33)) u_div (
    .clk_i, .rst_ni, .valid_i(s4_vld_q),
    .dvd_x_i({numx_q, {FRAC_BITS{1'b0}}}),
    .dvd_y_i({numy_q, {FRAC_BITS{1'b0}}}),
    .den_i(den_q), .side_i(side_q),
    .valid_o(dv_vld), .quo_x_o(qx), .quo_y_o(qy), .side_o(dv_side)
  );

  always_comb begin
    hw = $signed(SW'({width_q, {(FRAC_BITS - 1){1'b0}}}));
    hh = $signed(SW'({height_q, {(FRAC_BITS - 1){1'b0}}}));
    tx = dv_side.neg_x ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
    ty = dv_side.neg_y ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
    sx = hw + tx;
    sy = hh - ty;
    if (!((&sx[SW-1:31]) || !(|sx[SW-1:31]))) begin
      sx_sat = sx[SW-1] ? ppts_pkg::S32_MIN : ppts_pkg::S32_MAX;
    end else begin
      sx_sat = sx[31:0];
    end
    if (!((&sy[SW-1:31]) || !(|sy[SW-1:31]))) begin
      sy_sat = sy[SW-1] ? ppts_pkg::S32_MIN : ppts_pkg::S32_MAX;
    end else begin
      sy_sat = sy[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    vis_q   <= dv_side.vis;
    scr_x_q <= dv_side.vis ? sx_sat : dv_side.hid_x;
    scr_y_q <= dv_side.vis ? sy_sat : dv_side.hid_y;
  end

  assign done_o     = done_q;
  assign visible_o  = vis_q;
  assign screen_x_o = scr_x_q;
  assign screen_y_o = scr_y_q;

  a_dot_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_x == vld_y) && (vld_x == vld_w))
    else $error("clip dot product pipelines out of step");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("started item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##LAT !done_o)
    else $error("result without a started item");

endmodule

// ===== sim/tb_perspective_project_to_screen.sv =====
// Self-checking testbench for perspective_project_to_screen: drives world points,
// predicts each screen point in fixed point and compares every result strobe.
// Depends on ppts_pkg and the RTL of the block only.
module tb_perspective_project_to_screen;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Frac = 16;
  localparam int Latency = 51 + Frac;
  localparam longint CycleLimit = 400000;
  localparam longint NearLimit = ((longint'(1) << Frac) + 999) / 1000;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               vis;
  } screen_pt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [31:0] world_x_i = '0, world_y_i = '0, world_z_i = '0;
  logic done_o;
  logic signed [31:0] screen_x_o, screen_y_o;
  logic visible_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ppts_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  logic [63:0] view_regs [8];
  screen_pt_t pending_points[$];
  int errors = 0;
  int points_sent = 0;
  int points_seen = 0;
  int hidden_seen = 0;
  longint cycles = 0;

  perspective_project_to_screen DUT (.*);

  always #1 clk_i = ~clk_i;

  function automatic longint sat32(longint v);
    if (v > longint'(ppts_pkg::S32_MAX)) return longint'(ppts_pkg::S32_MAX);
    if (v < longint'(ppts_pkg::S32_MIN)) return longint'(ppts_pkg::S32_MIN);
    return v;
  endfunction

  function automatic longint clip_row(logic [63:0] rxy, logic [63:0] rzw,
                                      longint x, longint y, longint z);
    longint p[3];
    longint ip, fp, q;
    p[0] = longint'($signed(rxy[31:0])) * x;
    p[1] = longint'($signed(rxy[63:32])) * y;
    p[2] = longint'($signed(rzw[31:0])) * z;
    ip = 0;
    fp = 0;
    for (int i = 0; i < 3; i++) begin
      q = p[i] >>> Frac;
      ip += q;
      fp += p[i] - (q <<< Frac);
    end
    ip += fp >>> Frac;
    ip += longint'($signed(rzw[63:32]));
    return sat32(ip);
  endfunction

  function automatic longint pixel_offset(longint c, longint dim, longint w);
    longint mag, num, den, q, r, t;
    mag = (c < 0) ? -c : c;
    num = mag * dim;
    den = 2 * w;
    q = num / den;
    r = num % den;
    if (q >= (longint'(1) << 32)) t = longint'(1) << 40;
    else t = (q << Frac) + ((r << Frac) / den);
    return (c < 0) ? -t : t;
  endfunction

  function automatic longint hidden_scale(longint c);
    if (c > longint'(ppts_pkg::HID_POS_LIM)) return longint'(ppts_pkg::S32_MAX);
    if (c < longint'(ppts_pkg::HID_NEG_LIM)) return longint'(ppts_pkg::S32_MIN);
    return c * 100000;
  endfunction

  function automatic screen_pt_t project_point(longint x, longint y, longint z);
    screen_pt_t pt;
    longint cx, cy, cw, wd, ht;
    cx = clip_row(view_regs[ppts_pkg::REG_ROW0_XY], view_regs[ppts_pkg::REG_ROW0_ZW],
                  x, y, z);
    cy = clip_row(view_regs[ppts_pkg::REG_ROW1_XY], view_regs[ppts_pkg::REG_ROW1_ZW],
                  x, y, z);
    cw = clip_row(view_regs[ppts_pkg::REG_ROW3_XY], view_regs[ppts_pkg::REG_ROW3_ZW],
                  x, y, z);
    wd = longint'(view_regs[ppts_pkg::REG_WIDTH][ppts_pkg::DimW-1:0]);
    ht = longint'(view_regs[ppts_pkg::REG_HEIGHT][ppts_pkg::DimW-1:0]);
    if (cw < NearLimit) begin
      pt.sx = 32'(hidden_scale(cx));
      pt.sy = 32'(hidden_scale(cy));
      pt.vis = 1'b0;
    end else begin
      pt.sx = 32'(sat32(((wd << Frac) / 2) + pixel_offset(cx, wd, cw)));
      pt.sy = 32'(sat32(((ht << Frac) / 2) - pixel_offset(cy, ht, cw)));
      pt.vis = 1'b1;
    end
    return pt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (view_regs[i]) view_regs[i] = '0;
      view_regs[ppts_pkg::REG_WIDTH] = 64'd1920;
      view_regs[ppts_pkg::REG_HEIGHT] = 64'd1080;
    end else if (cfg_valid_i && cfg_ready_o && cfg_index_i < 8) begin
      view_regs[cfg_index_i] = cfg_data_i;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      pending_points.push_back(project_point(world_x_i, world_y_i, world_z_i));
      points_sent++;
    end
  end

  task automatic report(string what, longint got, longint exp);
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d", what, cycles, got, exp);
    errors++;
  endtask

  always @(posedge clk_i) begin
    screen_pt_t pt;
    if (rst_ni && done_o) begin
      points_seen++;
      if (!visible_o) hidden_seen++;
      if (pending_points.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        pt = pending_points.pop_front();
        if (screen_x_o !== pt.sx) report("screen_x", screen_x_o, pt.sx);
        if (screen_y_o !== pt.sy) report("screen_y", screen_y_o, pt.sy);
        if (visible_o !== pt.vis) report("visible", visible_o, pt.vis);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    world_x_i <= x;
    world_y_i <= y;
    world_z_i <= z;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(ppts_pkg::cfg_reg_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_matrix(logic [31:0] m00, m01, m02, m03, m10, m11, m12, m13,
                             m30, m31, m32, m33);
    write_reg(ppts_pkg::REG_ROW0_XY, {m01, m00});
    write_reg(ppts_pkg::REG_ROW0_ZW, {m03, m02});
    write_reg(ppts_pkg::REG_ROW1_XY, {m11, m10});
    write_reg(ppts_pkg::REG_ROW1_ZW, {m13, m12});
    write_reg(ppts_pkg::REG_ROW3_XY, {m31, m30});
    write_reg(ppts_pkg::REG_ROW3_ZW, {m33, m32});
  endtask

  function automatic logic [31:0] small_val(int mag_bits);
    return 32'($signed($urandom_range(0, (1 << (mag_bits + 1)) - 1)) - (1 << mag_bits));
  endfunction

  function automatic logic [31:0] coef_val();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return small_val(20);
      default: return small_val(17);
    endcase
  endfunction

  function automatic logic [31:0] coord_val();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return small_val(24);
  endfunction

  task automatic test_reset_defaults();
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_point(32'h0, 32'h0, 32'h0);
    drain();
  endtask

  task automatic test_directed();
    logic [31:0] one;
    one = 32'h0001_0000;
    load_matrix(one, 0, 0, 0, 0, one, 0, 0, 0, 0, 0, one);
    send_point(0, 0, 0);
    send_point(one, one, 0);
    send_point(-one, -one, 0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();
    // w set just below and exactly at the near plane limit.
    load_matrix(one, 0, 0, 0, 0, one, 0, 0, 0, 0, 0, 32'(NearLimit - 1));
    send_point(one, one, 0);
    send_point(32'd21474, -32'd21474, 0);
    send_point(32'd21475, -32'd21475, 0);
    drain();
    load_matrix(one, 0, 0, 0, 0, one, 0, 0, 0, 0, 0, 32'(NearLimit));
    send_point(one, -one, 0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 0);
    drain();
    // w depends on z, so negative and zero depths are hidden.
    load_matrix(one, 0, 0, 0, 0, one, 0, 0, 0, 0, one, 0);
    send_point(one, one, -one);
    send_point(one, one, 0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    drain();
    write_reg(ppts_pkg::REG_WIDTH, 64'd0);
    write_reg(ppts_pkg::REG_HEIGHT, 64'h3fff);
    send_point(one, one, one);
    send_point(32'h8000_0000, 32'h7fff_ffff, one);
    drain();
    write_reg(ppts_pkg::REG_WIDTH, 64'd8192);
    write_reg(ppts_pkg::REG_HEIGHT, 64'd1);
    send_point(one, -one, 32'h0000_0100);
    send_point(-one, one, one);
    drain();
  endtask

  task automatic test_random_phases();
    logic [31:0] w_coef [4];
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(ppts_pkg::REG_WIDTH, 64'd1);
          write_reg(ppts_pkg::REG_HEIGHT, 64'd1);
        end
        1: begin
          write_reg(ppts_pkg::REG_WIDTH, 64'd8192);
          write_reg(ppts_pkg::REG_HEIGHT, 64'd8192);
        end
        default: begin
          write_reg(ppts_pkg::REG_WIDTH, 64'($urandom_range(1, 8192)));
          write_reg(ppts_pkg::REG_HEIGHT, 64'($urandom_range(1, 8192)));
        end
      endcase
      if (ph == 7) begin
        foreach (w_coef[i]) w_coef[i] = $urandom;
      end else begin
        for (int i = 0; i < 3; i++) w_coef[i] = small_val(12);
        w_coef[3] = $urandom_range(1 << 14, 1 << 22);
      end
      load_matrix(coef_val(), coef_val(), coef_val(), coef_val(),
                  coef_val(), coef_val(), coef_val(), coef_val(),
                  w_coef[0], w_coef[1], w_coef[2], w_coef[3]);
      for (int n = 0; n < 200; n++) begin
        if (ph == 3 && n == 100) drain();
        send_point(coord_val(), coord_val(), coord_val());
      end
      drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random_phases();
    $display("Projected %0d points (%0d hidden) over directed cases and eight random",
             points_seen, hidden_seen);
    $display("matrix and viewport settings, including viewport extremes.");
    if (errors == 0 && points_seen == points_sent) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
